[rtl/ctf_pkg.sv]
package ctf_pkg;

  localparam int DataWidth  = 16;
  localparam int AngleWidth = 17;
  // output angle scale, 1/2^AngleFracBits degree; +-180 deg must fit AngleWidth
  localparam int AngleFracBits = 8;
  localparam int Guard      = 8;
  localparam int ZFrac      = 16;
  localparam int BlendFrac  = 20;
  localparam int GainInvQ16 = 39797;
  localparam int AtanEntries = 24;
  // CORDIC x/y word: 16-bit input << 8, plus growth for gain and the 180-degree flip
  localparam int CordWidth  = 28;
  // angle accumulator, 1/65536 degree, holds +-360 deg
  localparam int ZWidth     = 26;

  localparam logic CfgBlendWeight = 1'b0;
  localparam logic CfgTimeStep    = 1'b1;

  typedef struct packed {
    logic load;     // latch sample, start roll pass
    logic step;     // one CORDIC iteration
    logic gain;     // gain-correct magnitude, set up pitch pass
    logic save_roll;
    logic blend_mul;
    logic blend_fin;
  } ctf_cmd_t;

  function automatic logic signed [ZWidth-1:0] atan_q16(input logic [4:0] i);
    logic signed [ZWidth-1:0] r;
    unique case (i)
      5'd0:  r = 26'sd2949120;
      5'd1:  r = 26'sd1740967;
      5'd2:  r = 26'sd919879;
      5'd3:  r = 26'sd466945;
      5'd4:  r = 26'sd234379;
      5'd5:  r = 26'sd117304;
      5'd6:  r = 26'sd58666;
      5'd7:  r = 26'sd29335;
      5'd8:  r = 26'sd14668;
      5'd9:  r = 26'sd7334;
      5'd10: r = 26'sd3667;
      5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;
      5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;
      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;
      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/ctf_ctrl.sv]
module ctf_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output ctf_pkg::ctf_cmd_t  cmd,
  output logic [4:0]         iter
);
  import ctf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ROLL, S_GAIN, S_PITCH, S_MUL, S_FIN
  } state_t;

  state_t state;
  logic   last;

  assign last = (iter == 5'(CORDIC_STEPS - 1));
  // a new word enters only once the previous result is taken or is being taken
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    cmd = '0;
    cmd.load      = in_valid && in_ready;
    cmd.step      = (state == S_ROLL) || (state == S_PITCH);
    cmd.gain      = (state == S_GAIN);
    cmd.save_roll = (state == S_ROLL) && last;
    cmd.blend_mul = (state == S_MUL);
    cmd.blend_fin = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_ROLL;
            iter  <= '0;
          end
        end
        S_ROLL: begin
          iter <= iter + 5'd1;
          if (last) state <= S_GAIN;
        end
        S_GAIN: begin
          iter  <= '0;
          state <= S_PITCH;
        end
        S_PITCH: begin
          iter <= iter + 5'd1;
          if (last) state <= S_MUL;
        end
        S_MUL: state <= S_FIN;
        S_FIN: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/ctf_datapath.sv]
module ctf_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ctf_pkg::ctf_cmd_t                      cmd,
  input  logic [4:0]                             iter,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_index,
  input  logic                                   cfg_hit,
  input  logic [ctf_pkg::DataWidth-1:0]          cfg_data,
  input  logic signed [ctf_pkg::DataWidth-1:0]   accel_x,
  input  logic signed [ctf_pkg::DataWidth-1:0]   accel_y,
  input  logic signed [ctf_pkg::DataWidth-1:0]   accel_z,
  input  logic signed [ctf_pkg::DataWidth-1:0]   gyro_x,
  input  logic signed [ctf_pkg::DataWidth-1:0]   gyro_y,
  output logic signed [ctf_pkg::AngleWidth-1:0]  pitch,
  output logic signed [ctf_pkg::AngleWidth-1:0]  roll,
  output logic                                   first_sample
);
  import ctf_pkg::*;

  localparam int Up    = BlendFrac - AngleFracBits;
  localparam int ZSh   = ZFrac - AngleFracBits;
  localparam int Lim   = 180 << AngleFracBits;
  localparam int PW    = 40;  // predicted angle, 1/2^20 degree
  localparam int SW    = 58;  // weighted sum

  logic [15:0] blend_weight, time_step;
  logic signed [CordWidth-1:0] cx, cy, ax_n;
  logic signed [ZWidth-1:0]    cz, zr;
  logic signed [15:0] gx, gy;
  logic seeded;
  logic signed [AngleWidth-1:0] acc_roll, acc_pitch;

  function automatic logic signed [AngleWidth-1:0] sat_round(
      input logic signed [ZWidth-1:0] z);
    logic signed [ZWidth:0] t;
    t = ($signed({z[ZWidth-1], z}) + (ZWidth+1)'(1 << (ZSh - 1))) >>> ZSh;
    if (t > Lim) return AngleWidth'(Lim);
    if (t < -Lim) return -AngleWidth'(Lim);
    return t[AngleWidth-1:0];
  endfunction

  // vector start: zero vector, left-half flip
  function automatic void prep(input logic signed [CordWidth-1:0] x,
                               input logic signed [CordWidth-1:0] y,
                               output logic signed [CordWidth-1:0] xo,
                               output logic signed [CordWidth-1:0] yo,
                               output logic signed [ZWidth-1:0] zo);
    xo = x; yo = y; zo = '0;
    if (x < 0) begin
      zo = (y >= 0) ? ZWidth'(180 <<< ZFrac) : -ZWidth'(180 <<< ZFrac);
      xo = -x;
      yo = -y;
    end
  endfunction

  logic signed [CordWidth-1:0] xs, ys, px, py, mag;
  logic signed [ZWidth-1:0] pz;
  logic zero_vec, zero_roll;
  logic signed [CordWidth+16:0] mag_prod;

  assign xs = cx >>> iter;
  assign ys = cy >>> iter;
  assign mag_prod = cx * $signed({1'b0, 16'(GainInvQ16)});
  assign mag = mag_prod[CordWidth+15:16];

  // start vector for the roll pass on load, for the pitch pass otherwise
  always_comb begin
    if (cmd.load) begin
      prep(CordWidth'(accel_z) <<< Guard, CordWidth'(accel_y) <<< Guard, px, py, pz);
    end else begin
      prep(zero_roll ? '0 : mag, ax_n, px, py, pz);
    end
  end

  // blend
  logic [15:0] alpha;
  logic signed [PW-1:0] pred_p, pred_r;
  logic signed [SW-1:0] sp, sr;
  logic signed [AngleWidth-1:0] pitch_est, roll_est;
  assign alpha = (blend_weight > 16'd32768) ? 16'd32768 : blend_weight;

  function automatic logic signed [AngleWidth-1:0] fin(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] t;
    t = (s + (SW'(1) <<< (14 + Up))) >>> (15 + Up);
    if (t > Lim) return AngleWidth'(Lim);
    if (t < -Lim) return -AngleWidth'(Lim);
    return t[AngleWidth-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight <= 16'd32113;
      time_step    <= 16'd3277;
      seeded       <= 1'b0;
      pitch_est    <= '0;
      roll_est     <= '0;
      first_sample <= 1'b0;
    end else begin
      if (cfg_valid && cfg_hit) begin
        unique case (cfg_index)
          CfgBlendWeight: blend_weight <= cfg_data;
          CfgTimeStep:    time_step    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.blend_fin) begin
        seeded       <= 1'b1;
        first_sample <= !seeded;
        if (!seeded) begin
          pitch_est <= acc_pitch;
          roll_est  <= acc_roll;
        end else begin
          pitch_est <= fin(sp);
          roll_est  <= fin(sr);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx <= px; cy <= py; cz <= pz;
      zero_vec <= (accel_z == 0) && (accel_y == 0);
      ax_n <= -(CordWidth'(accel_x) <<< Guard);
      gx <= gyro_x;
      gy <= gyro_y;
    end else if (cmd.step) begin
      if (cy >= 0) begin
        cx <= cx + ys; cy <= cy - xs; cz <= cz + atan_q16(iter);
      end else begin
        cx <= cx - ys; cy <= cy + xs; cz <= cz - atan_q16(iter);
      end
      if (cmd.save_roll) zero_roll <= zero_vec;
    end else if (cmd.gain) begin
      zr <= zero_roll ? '0 : cz;
      cx <= px; cy <= py; cz <= pz;
      zero_vec <= ((zero_roll ? '0 : mag) == 0) && (ax_n == 0);
    end else if (cmd.blend_mul) begin
      acc_roll  <= sat_round(zr);
      acc_pitch <= sat_round(zero_vec ? '0 : cz);
      pred_p <= (PW'(pitch_est) <<< Up) + PW'(gy) * $signed({1'b0, time_step});
      pred_r <= (PW'(roll_est) <<< Up) + PW'(gx) * $signed({1'b0, time_step});
    end
  end

  assign sp = SW'(pred_p) * $signed({1'b0, alpha})
            + (SW'(acc_pitch) <<< Up) * $signed({1'b0, 16'd32768 - alpha});
  assign sr = SW'(pred_r) * $signed({1'b0, alpha})
            + (SW'(acc_roll) <<< Up) * $signed({1'b0, 16'd32768 - alpha});

  assign pitch = pitch_est;
  assign roll  = roll_est;
endmodule

[rtl/complementary_tilt_filter.sv]
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    accel_x/y/z, gyro_x/y
// out       output     out_valid / out_ready  pitch, roll, first_sample
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
// Each word runs through the single shared CORDIC iteration unit, roll pass then
// pitch pass, so a new word is taken only while the unit is idle.
// Reset restores register defaults and clears the seeded flag; no clearing pass.
// A result waits in the output register; the next word is taken once it goes.
module complementary_tilt_filter #(
  parameter int CORDIC_STEPS    = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ctf_pkg::DataWidth-1:0]  accel_x,
  input  logic signed [ctf_pkg::DataWidth-1:0]  accel_y,
  input  logic signed [ctf_pkg::DataWidth-1:0]  accel_z,
  input  logic signed [ctf_pkg::DataWidth-1:0]  gyro_x,
  input  logic signed [ctf_pkg::DataWidth-1:0]  gyro_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ctf_pkg::AngleWidth-1:0] pitch,
  output logic signed [ctf_pkg::AngleWidth-1:0] roll,
  output logic                                  first_sample,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [ctf_pkg::DataWidth-1:0]         cfg_data
);
  import ctf_pkg::*;

  ctf_cmd_t   cmd;
  logic [4:0] iter;

  assign cfg_ready = 1'b1;

  ctf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .iter
  );

  ctf_datapath u_dp (
    .clk, .rst, .cmd, .iter,
    .cfg_valid, .cfg_index(cfg_index[0]), .cfg_hit(cfg_index[1] == 1'b0), .cfg_data,
    .accel_x, .accel_y, .accel_z, .gyro_x, .gyro_y,
    .pitch, .roll, .first_sample
  );

  localparam int Lim = 180 << AngleFracBits;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pitch) && $stable(roll))
    else $error("result changed while stalled");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word taken while busy");
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch <= Lim) && (pitch >= -Lim) && (roll <= Lim) && (roll >= -Lim))
    else $error("angle out of range");
endmodule
